>>> rtl/rast_pkg.sv
// ----------------------------------------------------------------------------
// Repeating alarm slot table: shared package
// Action and result codes, sequencer states, and the structures passed
// between the front end, the slot engine and the result register.
// ----------------------------------------------------------------------------
package rast_pkg;

    localparam int MAX_RESULTS = 8;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_COUNT  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_DONE      = 3'd0,
        KIND_FIRED     = 3'd1,
        KIND_NOFREE    = 3'd2,
        KIND_NOTACTIVE = 3'd3,
        KIND_COUNT     = 3'd4,
        KIND_IDLE      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DELETE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] delay;
        logic [7:0]  repeats;
        logic [31:0] interval;
        logic [2:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [31:0] due;
        logic [7:0]  repeats;
        logic [31:0] interval;
    } slot_entry_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] slot;
        logic [3:0] pending;
        logic       last;
    } result_t;

endpackage

>>> rtl/repeating_alarm_slot_table.sv
// ----------------------------------------------------------------------------
// Repeating alarm slot table
// A seconds counter and a table of alarm slots with set, delete, count and
// tick actions; a tick fires every due slot and re-arms repeating ones.
//
//   Channel   Ports                                         Direction
//   s_        action, delay_seconds, repeat_count,          in
//             interval_seconds, slot_index
//   m_        kind, slot, pending_count, last                out
//
// A tick, a count and a set that finds no free slot step through every slot
// in the engine, one slot-table read and one evaluation per slot.
// A set ends at its free slot; a delete goes to its slot without a scan.
// Reset is synchronous and clears the counter and every active flag.
// A two-entry command queue and a result register let input and output
// stall independently of the engine.
// ----------------------------------------------------------------------------
module repeating_alarm_slot_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_delay_seconds,
    input  logic [7:0]  s_repeat_count,
    input  logic [31:0] s_interval_seconds,
    input  logic [2:0]  s_slot_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_slot,
    output logic [3:0]  m_pending_count,
    output logic        m_last
);
    import rast_pkg::*;

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_ready;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    result_t m_res;

    rast_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_delay_seconds   (s_delay_seconds),
        .s_repeat_count    (s_repeat_count),
        .s_interval_seconds(s_interval_seconds),
        .s_slot_index      (s_slot_index),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd)
    );

    rast_engine #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    rast_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_slot          = m_res.slot;
    assign m_pending_count = m_res.pending;
    assign m_last          = m_res.last;

    // Only fired results can be anything other than the final result of an item.
    a_single_results_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_FIRED) |-> m_last)
        else $error("non-fired result without last");

    a_pending_only_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_COUNT) |-> (m_pending_count == 4'd0))
        else $error("pending count set outside a count result");

    a_no_slot_on_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_NOFREE || m_kind == KIND_COUNT
                    || m_kind == KIND_IDLE) |-> (m_slot == 3'd0))
        else $error("slot set on a summary result");

    a_engine_busy_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !cmd_ready)
        else $error("engine took a command while emitting a result");

endmodule

>>> rtl/rast_front.sv
// ----------------------------------------------------------------------------
// Repeating alarm slot table: front end
// Accepts input items, decodes them into commands and holds them in a
// two-entry queue ahead of the slot engine.
// ----------------------------------------------------------------------------
module rast_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_action,
    input  logic [31:0]    s_delay_seconds,
    input  logic [7:0]     s_repeat_count,
    input  logic [31:0]    s_interval_seconds,
    input  logic [2:0]     s_slot_index,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output rast_pkg::cmd_t cmd
);
    import rast_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PW = $clog2(QDEPTH);

    cmd_t              q_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       fill_reg;
    cmd_t              decoded;
    logic              push;
    logic              pop;

    always_comb begin
        decoded.action   = action_t'(s_action);
        decoded.delay    = s_delay_seconds;
        decoded.repeats  = (s_repeat_count == 8'd0) ? 8'd1 : s_repeat_count;
        decoded.interval = s_interval_seconds;
        decoded.index    = s_slot_index;
    end

    assign s_ready   = (fill_reg != (PW + 1)'(QDEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/rast_engine.sv
// ----------------------------------------------------------------------------
// Repeating alarm slot table: slot engine
// Holds the seconds counter and the slot table, and carries out one command
// at a time; all but a delete step through the slots, read and evaluate each.
// ----------------------------------------------------------------------------
module rast_engine #(
    parameter int NUM_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rast_pkg::cmd_t    cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output rast_pkg::result_t res
);
    import rast_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDXW = (SLOT_W > 3) ? SLOT_W : 3;

    slot_entry_t          mem [NUM_SLOTS];
    slot_entry_t          rd_reg;
    slot_entry_t          wr_data;
    logic                 mem_we;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [31:0]          now_reg, now_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [SLOT_W-1:0]    scan_reg, scan_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [2:0]           hold_slot_reg, hold_slot_next;
    logic [3:0]           fired_reg, fired_next;
    logic [3:0]           cnt_reg, cnt_next;

    logic [IDXW-1:0]      scan_wide;
    logic [IDXW-1:0]      del_idx;
    logic                 del_ok;
    logic                 last_slot;
    logic                 fires;
    logic                 advance;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[scan_reg] <= wr_data;
        end
        rd_reg <= mem[scan_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            active_reg     <= '0;
            scan_reg       <= '0;
            hold_valid_reg <= 1'b0;
            fired_reg      <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            active_reg     <= active_next;
            scan_reg       <= scan_next;
            hold_valid_reg <= hold_valid_next;
            fired_reg      <= fired_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        hold_slot_reg <= hold_slot_next;
    end

    assign scan_wide = IDXW'(scan_reg);
    assign del_idx   = IDXW'(cmd_reg.index);
    assign del_ok    = ({1'b0, del_idx} < (IDXW + 1)'(NUM_SLOTS))
                       && active_reg[del_idx[SLOT_W-1:0]];
    assign last_slot = (scan_reg == SLOT_W'(NUM_SLOTS - 1));
    assign fires     = active_reg[scan_reg] && !(rd_reg.due > now_reg)
                       && (fired_reg < 4'(MAX_RESULTS));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        active_next     = active_reg;
        scan_next       = scan_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        fired_next      = fired_reg;
        cnt_next        = cnt_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        res.kind        = KIND_DONE;
        res.slot        = 3'd0;
        res.pending     = 4'd0;
        res.last        = 1'b1;
        mem_we          = 1'b0;
        wr_data         = rd_reg;
        advance         = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next        = cmd;
                    scan_next       = '0;
                    hold_valid_next = 1'b0;
                    fired_next      = '0;
                    cnt_next        = '0;
                    if (cmd.action == ACT_TICK) begin
                        now_next = now_reg + 32'd1;
                    end
                    state_next = (cmd.action == ACT_DELETE) ? ST_DELETE : ST_READ;
                end
            end

            ST_READ: begin
                state_next = ST_EVAL;
            end

            ST_EVAL: begin
                unique case (cmd_reg.action)
                    ACT_TICK: begin
                        if (fires) begin
                            res_valid = hold_valid_reg;
                            res.kind  = KIND_FIRED;
                            res.slot  = hold_slot_reg;
                            res.last  = 1'b0;
                            if (hold_valid_reg && !res_ready) begin
                                advance = 1'b0;
                            end else begin
                                hold_valid_next = 1'b1;
                                hold_slot_next  = scan_wide[2:0];
                                fired_next      = fired_reg + 4'd1;
                                if (rd_reg.repeats > 8'd1) begin
                                    mem_we          = 1'b1;
                                    wr_data.due     = rd_reg.due + rd_reg.interval;
                                    wr_data.repeats = rd_reg.repeats - 8'd1;
                                end else begin
                                    active_next[scan_reg] = 1'b0;
                                end
                            end
                        end
                    end
                    ACT_SET: begin
                        if (!active_reg[scan_reg]) begin
                            advance   = 1'b0;
                            res_valid = 1'b1;
                            res.kind  = KIND_DONE;
                            res.slot  = scan_wide[2:0];
                            if (res_ready) begin
                                mem_we                = 1'b1;
                                wr_data.due           = now_reg + cmd_reg.delay;
                                wr_data.repeats       = cmd_reg.repeats;
                                wr_data.interval      = cmd_reg.interval;
                                active_next[scan_reg] = 1'b1;
                                state_next            = ST_IDLE;
                            end
                        end
                    end
                    ACT_COUNT: begin
                        if (active_reg[scan_reg] && (rd_reg.due > now_reg)
                            && (cnt_reg < COUNT_MAX)) begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                    ACT_DELETE: begin
                        state_next = ST_IDLE;
                        advance    = 1'b0;
                    end
                endcase
                if (advance) begin
                    if (last_slot) begin
                        state_next = ST_FINISH;
                    end else begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end

            ST_DELETE: begin
                res_valid = 1'b1;
                res.kind  = del_ok ? KIND_DONE : KIND_NOTACTIVE;
                res.slot  = cmd_reg.index;
                if (res_ready) begin
                    if (del_ok) begin
                        active_next[del_idx[SLOT_W-1:0]] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FINISH: begin
                res_valid = 1'b1;
                unique case (cmd_reg.action)
                    ACT_TICK: begin
                        res.kind = hold_valid_reg ? KIND_FIRED : KIND_IDLE;
                        res.slot = hold_valid_reg ? hold_slot_reg : 3'd0;
                    end
                    ACT_COUNT: begin
                        res.kind    = KIND_COUNT;
                        res.pending = cnt_reg;
                    end
                    ACT_SET, ACT_DELETE: begin
                        res.kind = KIND_NOFREE;
                    end
                endcase
                if (res_ready) begin
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rast_out.sv
// ----------------------------------------------------------------------------
// Repeating alarm slot table: result register
// Holds one result for the output channel so that the engine can go on while
// the consumer stalls.
// ----------------------------------------------------------------------------
module rast_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  rast_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output rast_pkg::result_t m_res
);
    import rast_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule
